FILE: design/nnis_pkg.sv
// Package for the nearest-neighbor image scaler: sizes, codes, states and helpers.
package nnis_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 32;

    localparam int CFG_W   = 9;
    localparam int IDX_W   = 2;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DIV_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + CFG_W;
    localparam int CNT_W   = $clog2(DIV_W);

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_REQUEST = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_ADDR = 4'b0100,
        ST_DATA = 4'b1000
    } t_state;

    // A size of zero acts as one, and a size above the frame store's limit saturates.
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v, input int maxv);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (int'(v) > maxv) begin
            res = CFG_W'(maxv);
        end
        return res;
    endfunction

endpackage

FILE: design/nnis_in_if.sv
// Input channel of the scaler: command words with an optional source pixel.
interface nnis_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      command;
    logic [nnis_pkg::PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output command, output pixel_value, input ready);
    modport sink   (input valid, input command, input pixel_value, output ready);
endinterface

FILE: design/nnis_out_if.sv
// Output channel of the scaler: scaled pixels with row and frame end marks.
interface nnis_out_if;
    logic                            valid;
    logic                            ready;
    logic [nnis_pkg::PIXEL_BITS-1:0] pixel_out;
    logic                            row_end;
    logic                            frame_end;

    modport source (output valid, output pixel_out, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                    output ready);
endinterface

FILE: design/nnis_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module nnis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

FILE: design/nearest_neighbor_image_scaler_core.sv
// Nearest-neighbor image scaler core: frame store, cursors and quotient unit.
//
// Load words write source pixels in raster order into an on-chip frame store, and
// restart words clear both cursors. A request word returns one scaled pixel and
// occupies the block until that pixel is in the output register: the source
// coordinates come from a bit-serial restoring divider, one quotient bit per
// cycle in ST_DIV, followed by ST_ADDR to address the frame store and ST_DATA
// for its registered read, where the block waits while the output register is full.
// The result sits in an output register, so the next word is taken while it waits.
// Entries of the frame store are undefined until loaded; there is no clearing pass.
module nearest_neighbor_image_scaler_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nnis_in_if.sink                       i_in,
    nnis_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [nnis_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [nnis_pkg::CFG_W-1:0]    i_cfg_data
);
    localparam int CFG_W  = nnis_pkg::CFG_W;
    localparam int COL_W  = nnis_pkg::COL_W;
    localparam int ROW_W  = nnis_pkg::ROW_W;
    localparam int ADDR_W = nnis_pkg::ADDR_W;
    localparam int DIV_W  = nnis_pkg::DIV_W;
    localparam int CNT_W  = nnis_pkg::CNT_W;
    localparam int PIX_W  = nnis_pkg::PIXEL_BITS;

    nnis_pkg::t_state r_state, n_state;
    logic [COL_W-1:0] r_load_col, n_load_col, r_out_col, n_out_col;
    logic [ROW_W-1:0] r_load_row, n_load_row, r_out_row, n_out_row;
    logic [CFG_W-1:0] r_src_width, n_src_width, r_src_height, n_src_height;
    logic [CFG_W-1:0] r_dst_width, n_dst_width, r_dst_height, n_dst_height;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_quo_x, n_quo_x, r_quo_y, n_quo_y;
    logic [CFG_W-1:0] r_rem_x, n_rem_x, r_rem_y, n_rem_y;
    logic             r_rend, n_rend, r_fend, n_fend;
    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_pixel_out, n_pixel_out;
    logic             r_row_end, n_row_end, r_frame_end, n_frame_end;

    logic [CFG_W-1:0]  sw, sh, dw, dh;
    logic              in_acc, out_free;
    logic [CFG_W:0]    trial_x, trial_y;
    logic [COL_W-1:0]  ld_col, sx;
    logic [ROW_W-1:0]  ld_row, sy;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [PIX_W-1:0]  rd_data;
    logic              rend_now;

    assign sw = nnis_pkg::eff_size(r_src_width, nnis_pkg::MAX_WIDTH);
    assign sh = nnis_pkg::eff_size(r_src_height, nnis_pkg::MAX_HEIGHT);
    assign dw = nnis_pkg::eff_size(r_dst_width, nnis_pkg::MAX_WIDTH);
    assign dh = nnis_pkg::eff_size(r_dst_height, nnis_pkg::MAX_HEIGHT);

    assign i_in.ready      = (r_state == nnis_pkg::ST_IDLE);
    assign in_acc          = i_in.valid && i_in.ready;
    assign out_free        = !r_out_valid || o_out.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.pixel_out = r_pixel_out;
    assign o_out.row_end   = r_row_end;
    assign o_out.frame_end = r_frame_end;

    // A cursor left past a shrunken image writes into the last column or row.
    assign ld_col = (int'(r_load_col) < int'(sw)) ? r_load_col : COL_W'(sw - CFG_W'(1));
    assign ld_row = (int'(r_load_row) < int'(sh)) ? r_load_row : ROW_W'(sh - CFG_W'(1));
    assign wr_en  = in_acc && (i_in.command == nnis_pkg::CMD_LOAD);
    assign wr_addr = ADDR_W'(ld_row) * ADDR_W'(nnis_pkg::MAX_WIDTH) + ADDR_W'(ld_col);

    assign sx = (r_quo_x >= DIV_W'(sw)) ? COL_W'(sw - CFG_W'(1)) : COL_W'(r_quo_x);
    assign sy = (r_quo_y >= DIV_W'(sh)) ? ROW_W'(sh - CFG_W'(1)) : ROW_W'(r_quo_y);
    assign rd_en   = (r_state == nnis_pkg::ST_ADDR);
    assign rd_addr = ADDR_W'(sy) * ADDR_W'(nnis_pkg::MAX_WIDTH) + ADDR_W'(sx);

    assign trial_x  = {r_rem_x, r_quo_x[DIV_W-1]};
    assign trial_y  = {r_rem_y, r_quo_y[DIV_W-1]};
    assign rend_now = (int'(r_out_col) + 1 >= int'(dw));

    nnis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (nnis_pkg::DEPTH)
    ) u_frame (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.pixel_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_load_col   = r_load_col;
        n_load_row   = r_load_row;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_src_width  = r_src_width;
        n_src_height = r_src_height;
        n_dst_width  = r_dst_width;
        n_dst_height = r_dst_height;
        n_cnt        = r_cnt;
        n_quo_x      = r_quo_x;
        n_quo_y      = r_quo_y;
        n_rem_x      = r_rem_x;
        n_rem_y      = r_rem_y;
        n_rend       = r_rend;
        n_fend       = r_fend;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_pixel_out  = r_pixel_out;
        n_row_end    = r_row_end;
        n_frame_end  = r_frame_end;

        if (i_cfg_we) begin
            case (i_cfg_index)
                nnis_pkg::REG_SRC_WIDTH:  n_src_width  = i_cfg_data;
                nnis_pkg::REG_SRC_HEIGHT: n_src_height = i_cfg_data;
                nnis_pkg::REG_DST_WIDTH:  n_dst_width  = i_cfg_data;
                nnis_pkg::REG_DST_HEIGHT: n_dst_height = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            nnis_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_in.command)
                        nnis_pkg::CMD_LOAD: begin
                            if (int'(r_load_col) + 1 >= int'(sw)) begin
                                n_load_col = '0;
                                n_load_row = (int'(r_load_row) + 1 >= int'(sh)) ?
                                             '0 : r_load_row + ROW_W'(1);
                            end else begin
                                n_load_col = r_load_col + COL_W'(1);
                            end
                        end
                        nnis_pkg::CMD_RESTART: begin
                            n_load_col = '0;
                            n_load_row = '0;
                            n_out_col  = '0;
                            n_out_row  = '0;
                        end
                        nnis_pkg::CMD_REQUEST: begin
                            // The dividends enter the shift registers; quotient bits
                            // shift in from the bottom as the dividend shifts out.
                            n_quo_x = DIV_W'(r_out_col) * DIV_W'(sw);
                            n_quo_y = DIV_W'(r_out_row) * DIV_W'(sh);
                            n_rem_x = '0;
                            n_rem_y = '0;
                            n_cnt   = CNT_W'(DIV_W - 1);
                            n_rend  = rend_now;
                            n_fend  = rend_now && (int'(r_out_row) + 1 >= int'(dh));
                            if (rend_now) begin
                                n_out_col = '0;
                                n_out_row = (int'(r_out_row) + 1 >= int'(dh)) ?
                                            '0 : r_out_row + ROW_W'(1);
                            end else begin
                                n_out_col = r_out_col + COL_W'(1);
                            end
                            n_state = nnis_pkg::ST_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            nnis_pkg::ST_DIV: begin
                if (trial_x >= {1'b0, dw}) begin
                    n_rem_x = CFG_W'(trial_x - {1'b0, dw});
                    n_quo_x = {r_quo_x[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem_x = CFG_W'(trial_x);
                    n_quo_x = {r_quo_x[DIV_W-2:0], 1'b0};
                end
                if (trial_y >= {1'b0, dh}) begin
                    n_rem_y = CFG_W'(trial_y - {1'b0, dh});
                    n_quo_y = {r_quo_y[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem_y = CFG_W'(trial_y);
                    n_quo_y = {r_quo_y[DIV_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = nnis_pkg::ST_ADDR;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            nnis_pkg::ST_ADDR: begin
                n_state = nnis_pkg::ST_DATA;
            end
            nnis_pkg::ST_DATA: begin
                // The read data holds until the output register can take it.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_pixel_out = rd_data;
                    n_row_end   = r_rend;
                    n_frame_end = r_fend;
                    n_state     = nnis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nnis_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nnis_pkg::ST_IDLE;
            r_load_col   <= '0;
            r_load_row   <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_src_width  <= CFG_W'(1);
            r_src_height <= CFG_W'(1);
            r_dst_width  <= CFG_W'(1);
            r_dst_height <= CFG_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_col   <= n_load_col;
            r_load_row   <= n_load_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_src_width  <= n_src_width;
            r_src_height <= n_src_height;
            r_dst_width  <= n_dst_width;
            r_dst_height <= n_dst_height;
            r_out_valid  <= n_out_valid;
        end
        r_cnt       <= n_cnt;
        r_quo_x     <= n_quo_x;
        r_quo_y     <= n_quo_y;
        r_rem_x     <= n_rem_x;
        r_rem_y     <= n_rem_y;
        r_rend      <= n_rend;
        r_fend      <= n_fend;
        r_pixel_out <= n_pixel_out;
        r_row_end   <= n_row_end;
        r_frame_end <= n_frame_end;
    end

    a_req_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.command == nnis_pkg::CMD_REQUEST) |=> r_state == nnis_pkg::ST_DIV)
        else $error("request word did not start the divider");

    a_div_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nnis_pkg::ST_DIV && r_cnt != '0)
        |=> (r_state == nnis_pkg::ST_DIV && r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("divider left early or skipped a step");

    a_read_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == nnis_pkg::ST_ADDR |=> r_state == nnis_pkg::ST_DATA)
        else $error("frame store read not followed by data capture");

    a_data_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nnis_pkg::ST_DATA && out_free)
        |=> (r_out_valid && r_state == nnis_pkg::ST_IDLE))
        else $error("read word not moved into the output register");

    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_frame_end || r_row_end))
        else $error("frame end marked without row end");

endmodule

FILE: tb/sv/nnis_scaled_pixel_checker.sv
`timescale 1ns / 100ps
// Scaled-pixel checker: follows the scaler's words, predicts each output pixel and compares.
module nnis_scaled_pixel_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    nnis_in_if                           i_in,
    nnis_out_if                          i_out,
    input  logic                         i_cfg_we,
    input  logic [nnis_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [nnis_pkg::CFG_W-1:0]   i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct packed {
        logic [nnis_pkg::PIXEL_BITS-1:0] pixel;
        logic                            row_end;
        logic                            frame_end;
    } t_scaled_pixel;

    logic [nnis_pkg::PIXEL_BITS-1:0] frame_store [nnis_pkg::DEPTH];
    logic [nnis_pkg::CFG_W-1:0]      src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [nnis_pkg::COL_W-1:0]      load_col, out_col;
    logic [nnis_pkg::ROW_W-1:0]      load_row, out_row;
    t_scaled_pixel                   due_pixels [$];
    int                              pixels_seen = 0;
    int                              fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic int fit_size(input logic [nnis_pkg::CFG_W-1:0] v, input int limit);
        if (v == '0) begin
            return 1;
        end
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] pixel %0d: %s", $time, pixels_seen, what);
        fail_count++;
    endtask

    task automatic apply_word(input logic [1:0] cmd,
                              input logic [nnis_pkg::PIXEL_BITS-1:0] pix);
        int            sw, sh, dw, dh, c, r, sx, sy;
        logic          last_col, last_row;
        t_scaled_pixel px;
        sw = fit_size(src_w_reg, nnis_pkg::MAX_WIDTH);
        sh = fit_size(src_h_reg, nnis_pkg::MAX_HEIGHT);
        dw = fit_size(dst_w_reg, nnis_pkg::MAX_WIDTH);
        dh = fit_size(dst_h_reg, nnis_pkg::MAX_HEIGHT);
        case (cmd)
            nnis_pkg::CMD_LOAD: begin
                // A cursor left beyond a shrunken source writes its last column or row.
                c = (int'(load_col) < sw) ? int'(load_col) : sw - 1;
                r = (int'(load_row) < sh) ? int'(load_row) : sh - 1;
                frame_store[r * nnis_pkg::MAX_WIDTH + c] = pix;
                if (int'(load_col) + 1 >= sw) begin
                    load_col = '0;
                    load_row = (int'(load_row) + 1 >= sh) ? '0 : load_row + 1'b1;
                end else begin
                    load_col = load_col + 1'b1;
                end
            end
            nnis_pkg::CMD_RESTART: begin
                load_col = '0;
                load_row = '0;
                out_col  = '0;
                out_row  = '0;
            end
            nnis_pkg::CMD_REQUEST: begin
                sx = (int'(out_col) * sw) / dw;
                sy = (int'(out_row) * sh) / dh;
                last_col = (int'(out_col) + 1 >= dw);
                last_row = (int'(out_row) + 1 >= dh);
                if (sx >= sw) begin
                    sx = sw - 1;
                end
                if (sy >= sh) begin
                    sy = sh - 1;
                end
                px.pixel     = frame_store[sy * nnis_pkg::MAX_WIDTH + sx];
                px.row_end   = last_col;
                px.frame_end = last_col && last_row;
                due_pixels.push_back(px);
                if (last_col) begin
                    out_col = '0;
                    out_row = last_row ? '0 : out_row + 1'b1;
                end else begin
                    out_col = out_col + 1'b1;
                end
            end
            default: begin
                // The unused command changes nothing.
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_scaled_pixel want;
        if (!i_rst_n) begin
            src_w_reg = nnis_pkg::CFG_W'(1);
            src_h_reg = nnis_pkg::CFG_W'(1);
            dst_w_reg = nnis_pkg::CFG_W'(1);
            dst_h_reg = nnis_pkg::CFG_W'(1);
            load_col  = '0;
            load_row  = '0;
            out_col   = '0;
            out_row   = '0;
            due_pixels.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (due_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, pixel %h", i_out.pixel_out));
                end else begin
                    want = due_pixels.pop_front();
                    if (i_out.pixel_out !== want.pixel) begin
                        report_mismatch($sformatf("pixel_out %h, expected %h",
                                                  i_out.pixel_out, want.pixel));
                    end
                    if (i_out.row_end !== want.row_end) begin
                        report_mismatch($sformatf("row_end %b, expected %b",
                                                  i_out.row_end, want.row_end));
                    end
                    if (i_out.frame_end !== want.frame_end) begin
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  i_out.frame_end, want.frame_end));
                    end
                end
                pixels_seen++;
            end
            if (i_in.valid && i_in.ready) begin
                apply_word(i_in.command, i_in.pixel_value);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    nnis_pkg::REG_SRC_WIDTH:  src_w_reg = i_cfg_data;
                    nnis_pkg::REG_SRC_HEIGHT: src_h_reg = i_cfg_data;
                    nnis_pkg::REG_DST_WIDTH:  dst_w_reg = i_cfg_data;
                    nnis_pkg::REG_DST_HEIGHT: dst_h_reg = i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        o_pending = due_pixels.size();
    end

endmodule

FILE: tb/sv/nearest_neighbor_image_scaler_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the scaler core: clock, reset, size writes, word stimulus and verdict.
module nearest_neighbor_image_scaler_core_test;

    localparam logic [1:0] CMD_UNUSED       = 2'd3;
    localparam int         WORD_TARGET      = 1650;
    localparam int         SETTLE_CYCLES    = nnis_pkg::DIV_W + 8;
    localparam int         LONG_HOLD_CYCLES = 400;
    localparam int         TIMEOUT_NS       = 25_000_000;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [nnis_pkg::IDX_W-1:0] cfg_index = '0;
    logic [nnis_pkg::CFG_W-1:0] cfg_data  = '0;
    int                         pixel_errors;
    int                         results_due;
    int                         words_sent    = 0;
    bit                         steady_sender = 1'b0;
    bit                         hold_output   = 1'b0;
    logic [nnis_pkg::CFG_W-1:0] size_reg [4];
    bit                         loaded_map [nnis_pkg::DEPTH];

    nnis_in_if  in_ch ();
    nnis_out_if out_ch ();

    nearest_neighbor_image_scaler_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    nnis_scaled_pixel_checker u_pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (pixel_errors),
        .o_pending    (results_due)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("nearest_neighbor_image_scaler_core_test NOT OK");
        $finish;
    end

    // Output side: runs of ready and of stall, with a rare long stall and one forced hold-off.
    initial begin : result_ready
        int   run_len;
        int   r;
        logic level;
        out_ch.ready = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (hold_output) begin
                hold_output = 1'b0;
                level       = 1'b0;
                run_len     = LONG_HOLD_CYCLES;
            end else if (r < 55) begin
                level   = 1'b1;
                run_len = $urandom_range(1, 40);
            end else if (r < 85) begin
                level   = 1'b0;
                run_len = $urandom_range(1, 3);
            end else if (r < 97) begin
                level   = 1'b0;
                run_len = $urandom_range(4, 20);
            end else begin
                level   = 1'b0;
                run_len = $urandom_range(40, 150);
            end
            repeat (run_len) begin
                @(negedge i_clk);
                out_ch.ready <= level;
            end
        end
    end

    function automatic int clamp_dim(input logic [nnis_pkg::CFG_W-1:0] v, input int limit);
        if (v == '0) begin
            return 1;
        end
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    function automatic logic [nnis_pkg::PIXEL_BITS-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic logic [nnis_pkg::CFG_W-1:0] pick_size(input bit allow_wide);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return '0;
        end
        if (allow_wide && r == 1) begin
            return nnis_pkg::CFG_W'($urandom_range(9, 511));
        end
        return nnis_pkg::CFG_W'($urandom_range(1, 6));
    endfunction

    // Offers one word after an optional gap and returns at the falling edge after acceptance.
    task automatic push_word(input logic [1:0] cmd,
                             input logic [nnis_pkg::PIXEL_BITS-1:0] pix);
        int gap;
        int r;
        gap = 0;
        r   = $urandom_range(0, 99);
        if (!steady_sender) begin
            if (r >= 98) begin
                gap = $urandom_range(25, 80);
            end else if (r >= 88) begin
                gap = $urandom_range(4, 12);
            end else if (r >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.pixel_value <= pix;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        @(negedge i_clk);
        if (cmd != CMD_UNUSED) begin
            words_sent++;
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (results_due != 0);
    endtask

    // A load or restart can still be in flight after the last pixel, so wait a little more.
    task automatic wait_idle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_sizes(input logic [nnis_pkg::CFG_W-1:0] src_w, src_h, dst_w, dst_h,
                             input logic [3:0] write_mask);
        logic [nnis_pkg::CFG_W-1:0] vals [4];
        vals[nnis_pkg::REG_SRC_WIDTH]  = src_w;
        vals[nnis_pkg::REG_SRC_HEIGHT] = src_h;
        vals[nnis_pkg::REG_DST_WIDTH]  = dst_w;
        vals[nnis_pkg::REG_DST_HEIGHT] = dst_h;
        for (int k = 0; k < 4; k++) begin
            if (write_mask[k]) begin
                cfg_we    <= 1'b1;
                cfg_index <= nnis_pkg::IDX_W'(k);
                cfg_data  <= vals[k];
                size_reg[k] = vals[k];
                @(negedge i_clk);
            end
        end
        cfg_we <= 1'b0;
    endtask

    // Restart, then load one whole source frame so that every pixel a request can reach is set.
    task automatic fill_source();
        int sw, sh;
        sw = clamp_dim(size_reg[nnis_pkg::REG_SRC_WIDTH], nnis_pkg::MAX_WIDTH);
        sh = clamp_dim(size_reg[nnis_pkg::REG_SRC_HEIGHT], nnis_pkg::MAX_HEIGHT);
        push_word(nnis_pkg::CMD_RESTART, pick_pixel());
        for (int r = 0; r < sh; r++) begin
            for (int c = 0; c < sw; c++) begin
                push_word(nnis_pkg::CMD_LOAD, pick_pixel());
                loaded_map[r * nnis_pkg::MAX_WIDTH + c] = 1'b1;
            end
        end
    endtask

    task automatic run_phase(input logic [nnis_pkg::CFG_W-1:0] src_w, src_h, dst_w, dst_h,
                             input int max_req, input bit keep_cursors);
        int   sw, sh, n_req, r;
        bit   covered;
        logic [3:0] mask;
        wait_idle();
        mask = keep_cursors ? 4'($urandom_range(1, 15)) : 4'hF;
        set_sizes(src_w, src_h, dst_w, dst_h, mask);
        sw = clamp_dim(size_reg[nnis_pkg::REG_SRC_WIDTH], nnis_pkg::MAX_WIDTH);
        sh = clamp_dim(size_reg[nnis_pkg::REG_SRC_HEIGHT], nnis_pkg::MAX_HEIGHT);
        covered = 1'b1;
        for (int y = 0; y < sh; y++) begin
            for (int x = 0; x < sw; x++) begin
                if (!loaded_map[y * nnis_pkg::MAX_WIDTH + x]) begin
                    covered = 1'b0;
                end
            end
        end
        // Cursors carry over only when the new source area is already loaded.
        if (!keep_cursors || !covered) begin
            fill_source();
        end
        n_req = clamp_dim(size_reg[nnis_pkg::REG_DST_WIDTH], nnis_pkg::MAX_WIDTH)
              * clamp_dim(size_reg[nnis_pkg::REG_DST_HEIGHT], nnis_pkg::MAX_HEIGHT)
              * $urandom_range(1, 2);
        if (n_req > max_req) begin
            n_req = max_req;
        end
        // A long request burst is where the output hold-off backs the block up.
        if (n_req >= 200) begin
            hold_output = 1'b1;
        end
        for (int k = 0; k < n_req; k++) begin
            r = $urandom_range(0, 199);
            // Loads between requests land inside the loaded area, since the cursor clamps.
            if (r < 6) begin
                push_word(CMD_UNUSED, pick_pixel());
            end else if (r < 12) begin
                push_word(nnis_pkg::CMD_LOAD, pick_pixel());
            end else if (r < 15) begin
                push_word(nnis_pkg::CMD_RESTART, pick_pixel());
            end else if (r < 19) begin
                drain();
            end
            push_word(nnis_pkg::CMD_REQUEST, pick_pixel());
        end
    endtask

    initial begin : stimulus
        in_ch.valid       = 1'b0;
        in_ch.command     = nnis_pkg::CMD_LOAD;
        in_ch.pixel_value = '0;
        foreach (size_reg[k]) begin
            size_reg[k] = nnis_pkg::CFG_W'(1);
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sizes start at 1 x 1: one pixel, every command, a pause until the output is empty.
        push_word(nnis_pkg::CMD_LOAD, '1);
        loaded_map[0] = 1'b1;
        push_word(nnis_pkg::CMD_REQUEST, '0);
        push_word(CMD_UNUSED, '1);
        push_word(nnis_pkg::CMD_REQUEST, pick_pixel());
        drain();
        push_word(nnis_pkg::CMD_RESTART, '1);
        push_word(nnis_pkg::CMD_LOAD, '0);
        push_word(nnis_pkg::CMD_REQUEST, '1);

        // Zero sizes act as one: a 1 x 2 source stretched to 3 x 1, run past a frame end.
        wait_idle();
        set_sizes('0, nnis_pkg::CFG_W'(2), nnis_pkg::CFG_W'(3), '0, 4'hF);
        fill_source();
        repeat (5) push_word(nnis_pkg::CMD_REQUEST, pick_pixel());

        // Narrow the output in mid-frame: the column cursor now lies past the new width,
        // so it wraps and its source column saturates.
        wait_idle();
        set_sizes('0, '0, nnis_pkg::CFG_W'(2), nnis_pkg::CFG_W'(3), 4'b1100);
        repeat (4) push_word(nnis_pkg::CMD_REQUEST, pick_pixel());

        // Largest sizes, written both as the limit and as values above it.
        run_phase(nnis_pkg::CFG_W'(511), '0, '0, nnis_pkg::CFG_W'(256), 40, 1'b0);
        run_phase('0, nnis_pkg::CFG_W'(511), nnis_pkg::CFG_W'(511), '0, 256, 1'b0);

        while (words_sent < WORD_TARGET) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            run_phase(pick_size(1'b0), pick_size(1'b0), pick_size(1'b1), pick_size(1'b1),
                      $urandom_range(20, 120), $urandom_range(0, 3) == 0);
        end
        steady_sender = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pixel_errors == 0) begin
            $display("nearest_neighbor_image_scaler_core_test OK");
        end else begin
            $display("nearest_neighbor_image_scaler_core_test NOT OK");
        end
        $finish;
    end

endmodule
